// ----- design/euler_fly_camera_update_unit_defines.svh -----
// Assertion macros shared by the camera update unit.
`ifndef EULER_FLY_CAMERA_UPDATE_UNIT_DEFINES_SVH
`define EULER_FLY_CAMERA_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle while arst_n is low.
`define ECAM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("camera unit check failed");

// Next-cycle implication, sampled on clk, idle while arst_n is low.
`define ECAM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("camera unit check failed");

`endif

// ----- design/ecam_pkg.sv -----
// Types, codes, constants and the arctangent table of the camera update unit.
package ecam_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_STEPS_MAX = 24;

	// Event codes
	localparam logic [2:0] FN_FWD    = 3'd0;
	localparam logic [2:0] FN_BACK   = 3'd1;
	localparam logic [2:0] FN_LEFT   = 3'd2;
	localparam logic [2:0] FN_RIGHT  = 3'd3;
	localparam logic [2:0] FN_PAN    = 3'd4;
	localparam logic [2:0] FN_ZOOM   = 3'd5;
	localparam logic [2:0] FN_POSE   = 3'd6;
	localparam logic [2:0] FN_REPORT = 3'd7;

	// Result kinds
	localparam logic [2:0] KIND_POS   = 3'd0;
	localparam logic [2:0] KIND_FRONT = 3'd1;
	localparam logic [2:0] KIND_RIGHT = 3'd2;
	localparam logic [2:0] KIND_UP    = 3'd3;
	localparam logic [2:0] KIND_YPZ   = 3'd4;

	// Register indexes
	localparam logic [2:0] REG_MAX_SPEED   = 3'd0;
	localparam logic [2:0] REG_SENSITIVITY = 3'd1;
	localparam logic [2:0] REG_WORLD_UP_X  = 3'd2;
	localparam logic [2:0] REG_WORLD_UP_Y  = 3'd3;
	localparam logic [2:0] REG_WORLD_UP_Z  = 3'd4;

	localparam int DEG360      = 46080;
	localparam int DEG180      = 23040;
	localparam int DEG90       = 11520;
	localparam int PITCH_LIM   = 11392;
	localparam int ZOOM_MIN    = 256;
	localparam int ZOOM_MAX    = 11520;
	localparam int CORDIC_GAIN = 652032874;
	localparam int UNIT_Q14    = 16384;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} vec3_t;

	// Pick one component of a vector
	function automatic logic signed [15:0] vsel(vec3_t v, logic [1:0] k);
		case (k)
			2'd0: vsel = v.x;
			2'd1: vsel = v.y;
			default: vsel = v.z;
		endcase
	endfunction

	// atan(2^-i) in degrees * 2^16
	function automatic logic [21:0] atan_lut(logic [4:0] i);
		case (i)
			5'd0: atan_lut = 22'd2949120;
			5'd1: atan_lut = 22'd1740967;
			5'd2: atan_lut = 22'd919879;
			5'd3: atan_lut = 22'd466945;
			5'd4: atan_lut = 22'd234379;
			5'd5: atan_lut = 22'd117304;
			5'd6: atan_lut = 22'd58666;
			5'd7: atan_lut = 22'd29335;
			5'd8: atan_lut = 22'd14668;
			5'd9: atan_lut = 22'd7334;
			5'd10: atan_lut = 22'd3667;
			5'd11: atan_lut = 22'd1833;
			5'd12: atan_lut = 22'd917;
			5'd13: atan_lut = 22'd458;
			5'd14: atan_lut = 22'd229;
			5'd15: atan_lut = 22'd115;
			5'd16: atan_lut = 22'd57;
			5'd17: atan_lut = 22'd29;
			5'd18: atan_lut = 22'd14;
			5'd19: atan_lut = 22'd7;
			5'd20: atan_lut = 22'd4;
			5'd21: atan_lut = 22'd2;
			5'd22: atan_lut = 22'd1;
			default: atan_lut = 22'd0;
		endcase
	endfunction

endpackage

// ----- design/ecam_cordic.sv -----
// Iterative CORDIC giving cosine and sine of a Q9.7 degree angle in Q1.30.
module ecam_cordic #(
	parameter int STEPS = ecam_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [15:0]  angle,
	output logic                done,
	output logic signed [31:0]  cos_val,
	output logic signed [31:0]  sin_val
);
	import ecam_pkg::*;

	localparam int IW = $clog2(STEPS);

	logic              run_q;
	logic              done_q;
	logic              neg_q;
	logic [IW-1:0]     i_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [25:0] z_q;

	logic signed [16:0] a_in;
	logic signed [16:0] a_wr;
	logic signed [16:0] a_rd;
	logic               a_neg;
	logic signed [25:0] at_s;
	logic signed [33:0] x_neg;
	logic signed [33:0] y_neg;

	// Wrap into one turn, then fold into the right half plane
	always_comb begin
		a_in = 17'(angle);
		a_wr = a_in;
		if (a_in >= 17'sd23040) begin
			a_wr = a_in - 17'sd46080;
		end else if (a_in < -17'sd23040) begin
			a_wr = a_in + 17'sd46080;
		end
		a_rd  = a_wr;
		a_neg = 1'b0;
		if (a_wr > 17'sd11520) begin
			a_rd  = a_wr - 17'sd23040;
			a_neg = 1'b1;
		end else if (a_wr < -17'sd11520) begin
			a_rd  = a_wr + 17'sd23040;
			a_neg = 1'b1;
		end
		at_s = $signed({4'b0000, atan_lut(5'(i_q))});
	end

	// Rotate one step a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				if (i_q == IW'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= 34'sd652032874;
			y_q   <= '0;
			z_q   <= 26'(a_rd) <<< 9;
			neg_q <= a_neg;
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - (y_q >>> i_q);
				y_q <= y_q + (x_q >>> i_q);
				z_q <= z_q - at_s;
			end else begin
				x_q <= x_q + (y_q >>> i_q);
				y_q <= y_q - (x_q >>> i_q);
				z_q <= z_q + at_s;
			end
		end
	end

	assign x_neg   = neg_q ? -x_q : x_q;
	assign y_neg   = neg_q ? -y_q : y_q;
	assign cos_val = x_neg[31:0];
	assign sin_val = y_neg[31:0];
	assign done    = done_q;

endmodule

// ----- design/ecam_sqrt.sv -----
// Bit-pair integer square root of a 64-bit value, one result bit a cycle.
module ecam_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        done,
	output logic [31:0] root
);
	logic        run_q;
	logic        done_q;
	logic [4:0]  s_q;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bitv;
	logic [64:0] trial;

	assign bitv  = 64'd1 << {s_q, 1'b0};
	assign trial = {1'b0, r_q} + {1'b0, bitv};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			s_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				s_q   <= 5'd31;
			end else if (run_q) begin
				if (s_q == 5'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					s_q <= s_q - 1'b1;
				end
			end
		end
	end

	// Take a bit when the trial fits
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			r_q <= '0;
		end else if (run_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q <= v_q - trial[63:0];
				r_q <= (r_q >> 1) + bitv;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	assign root = r_q[31:0];
	assign done = done_q;

endmodule

// ----- design/ecam_div.sv -----
// Restoring divider giving a 15-bit quotient, one bit a cycle.
module ecam_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [45:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [14:0] quo
);
	logic        run_q;
	logic        done_q;
	logic [3:0]  s_q;
	logic [45:0] rem_q;
	logic [31:0] den_q;
	logic [14:0] q_q;
	logic [45:0] trial;

	assign trial = 46'(den_q) << s_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			s_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				s_q   <= 4'd14;
			end else if (run_q) begin
				if (s_q == 4'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					s_q <= s_q - 1'b1;
				end
			end
		end
	end

	// Subtract the shifted divisor where it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			q_q   <= '0;
		end else if (run_q) begin
			if (rem_q >= trial) begin
				rem_q     <= rem_q - trial;
				q_q[s_q]  <= 1'b1;
			end
		end
	end

	assign quo  = q_q;
	assign done = done_q;

endmodule

// ----- design/euler_fly_camera_update_unit.sv -----
// Fly camera pose unit: one event in, five result beats out (position, front, right, up, angles).
// Before the first beat an event runs the CORDIC for yaw and for pitch, then, for right and
// then for up, a 32-step square root and three 15-step divides.
// The beats then leave one a cycle unless stalled; one event is in flight at a time.
// Reset puts the registers and the pose at their defaults: yaw -90, zoom 90, looking down -z.
`include "euler_fly_camera_update_unit_defines.svh"
module euler_fly_camera_update_unit #(
	parameter int CORDIC_STEPS = ecam_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         func,
	input  logic [15:0]        dt,
	input  logic signed [15:0] x_offset,
	input  logic signed [15:0] y_offset,
	input  logic               constrain_pitch,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] yaw_in,
	input  logic signed [15:0] pitch_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic signed [31:0] comp_a,
	output logic signed [31:0] comp_b,
	output logic signed [31:0] comp_c,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import ecam_pkg::*;

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_EVT      = 5'd1;
	localparam logic [4:0] ST_MV_VEL   = 5'd2;
	localparam logic [4:0] ST_MV_MUL   = 5'd3;
	localparam logic [4:0] ST_MV_ACC   = 5'd4;
	localparam logic [4:0] ST_PAN_X    = 5'd5;
	localparam logic [4:0] ST_PAN_Y    = 5'd6;
	localparam logic [4:0] ST_WRAP     = 5'd7;
	localparam logic [4:0] ST_COR_Y    = 5'd8;
	localparam logic [4:0] ST_WAIT_Y   = 5'd9;
	localparam logic [4:0] ST_WAIT_P   = 5'd10;
	localparam logic [4:0] ST_FR_X     = 5'd11;
	localparam logic [4:0] ST_FR_Z     = 5'd12;
	localparam logic [4:0] ST_CR_MUL   = 5'd13;
	localparam logic [4:0] ST_CR_ACC   = 5'd14;
	localparam logic [4:0] ST_SQ_MUL   = 5'd15;
	localparam logic [4:0] ST_SQ_ACC   = 5'd16;
	localparam logic [4:0] ST_SQ_GO    = 5'd17;
	localparam logic [4:0] ST_SQRT     = 5'd18;
	localparam logic [4:0] ST_DIV_GO   = 5'd19;
	localparam logic [4:0] ST_DIV_WAIT = 5'd20;
	localparam logic [4:0] ST_OUT      = 5'd21;

	// Next and next-but-one axis for cross products
	function automatic logic [1:0] nxt1(logic [1:0] k);
		case (k)
			2'd0: nxt1 = 2'd1;
			2'd1: nxt1 = 2'd2;
			default: nxt1 = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] nxt2(logic [1:0] k);
		case (k)
			2'd0: nxt2 = 2'd2;
			2'd1: nxt2 = 2'd0;
			default: nxt2 = 2'd1;
		endcase
	endfunction

	function automatic logic signed [15:0] sat16(logic signed [17:0] v);
		if (v > 18'sd32767) begin
			sat16 = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			sat16 = 16'sh8000;
		end else begin
			sat16 = v[15:0];
		end
	endfunction

	// Configuration registers
	logic [15:0]        max_speed_q;
	logic [15:0]        sens_q;
	logic signed [15:0] wux_q;
	logic signed [15:0] wuy_q;
	logic signed [15:0] wuz_q;

	// Camera state
	logic signed [31:0] pos0_q;
	logic signed [31:0] pos1_q;
	logic signed [31:0] pos2_q;
	logic signed [15:0] yaw_q;
	logic signed [15:0] pitch_q;
	logic signed [15:0] zoom_q;
	vec3_t              front_q;
	vec3_t              right_q;
	vec3_t              up_q;

	// Latched event
	logic [2:0]         func_q;
	logic [15:0]        dt_q;
	logic signed [15:0] xo_q;
	logic signed [15:0] yo_q;
	logic               cons_q;
	logic signed [31:0] pin0_q;
	logic signed [31:0] pin1_q;
	logic signed [31:0] pin2_q;
	logic signed [15:0] yin_q;
	logic signed [15:0] pin_q;

	// Sequencer and work registers
	logic [4:0]         state_q;
	logic [1:0]         k_q;
	logic               t_q;
	logic               phase_q;
	logic [2:0]         kind_q;
	logic [31:0]        vel_q;
	logic signed [20:0] yaw_w_q;
	logic signed [31:0] cos_yaw_q;
	logic signed [31:0] sin_yaw_q;
	logic signed [31:0] cos_pit_q;
	logic signed [31:0] ctmp_q;
	logic signed [31:0] c0_q;
	logic signed [31:0] c1_q;
	logic signed [31:0] c2_q;
	logic [63:0]        sum_q;
	logic [31:0]        len_q;
	logic signed [15:0] n0_q;
	logic signed [15:0] n1_q;
	logic signed [63:0] mul_q;

	// Shared multiplier
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;

	vec3_t              wu;
	vec3_t              cr_a;
	vec3_t              cr_b;
	vec3_t              mv_v;
	logic signed [31:0] c_k;
	logic signed [31:0] pos_k;
	logic [31:0]        mag_k;

	logic               cor_start;
	logic signed [15:0] cor_angle;
	logic               cor_done;
	logic signed [31:0] cor_cos;
	logic signed [31:0] cor_sin;
	logic               sq_start;
	logic               sq_done;
	logic [31:0]        sq_root;
	logic               dv_start;
	logic [45:0]        dv_num;
	logic               dv_done;
	logic [14:0]        dv_quo;

	logic signed [63:0] mv_rnd;
	logic signed [26:0] mv_d;
	logic signed [32:0] mv_sum;
	logic signed [31:0] mv_new;
	logic signed [32:0] pan_p;
	logic signed [32:0] pan_r;
	logic signed [19:0] pan_d;
	logic signed [20:0] pit_s;
	logic signed [20:0] pit_c;
	logic signed [20:0] zm_s;
	logic signed [20:0] zm_c;
	logic signed [63:0] fr_r;
	logic signed [17:0] fr_v;
	logic signed [32:0] fy_r;
	logic signed [17:0] fy_v;
	logic signed [15:0] n_k;
	logic               in_take;
	logic               out_take;
	logic               cfg_wr;

	assign wu   = '{x: wux_q, y: wuy_q, z: wuz_q};
	assign cr_a = phase_q ? right_q : front_q;
	assign cr_b = phase_q ? front_q : wu;
	assign mv_v = (func_q == FN_FWD || func_q == FN_BACK) ? front_q : right_q;

	always_comb begin
		case (k_q)
			2'd0: begin
				c_k   = c0_q;
				pos_k = pos0_q;
			end
			2'd1: begin
				c_k   = c1_q;
				pos_k = pos1_q;
			end
			default: begin
				c_k   = c2_q;
				pos_k = pos2_q;
			end
		endcase
		mag_k = c_k[31] ? 32'(-c_k) : 32'(c_k);
	end

	// Select multiplier operands per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_EVT: begin
				if (func_q == FN_PAN) begin
					mul_a = 33'(xo_q);
					mul_b = $signed({17'b0, sens_q});
				end else begin
					mul_a = $signed({17'b0, max_speed_q});
					mul_b = $signed({17'b0, dt_q});
				end
			end
			ST_MV_MUL: begin
				mul_a = 33'(vsel(mv_v, k_q));
				mul_b = $signed({1'b0, vel_q});
			end
			ST_PAN_X: begin
				mul_a = 33'(yo_q);
				mul_b = $signed({17'b0, sens_q});
			end
			ST_WAIT_P: begin
				mul_a = 33'(cos_yaw_q);
				mul_b = 33'(cor_cos);
			end
			ST_FR_X: begin
				mul_a = 33'(sin_yaw_q);
				mul_b = 33'(cos_pit_q);
			end
			ST_CR_MUL: begin
				if (!t_q) begin
					mul_a = 33'(vsel(cr_a, nxt1(k_q)));
					mul_b = 33'(vsel(cr_b, nxt2(k_q)));
				end else begin
					mul_a = 33'(vsel(cr_a, nxt2(k_q)));
					mul_b = 33'(vsel(cr_b, nxt1(k_q)));
				end
			end
			ST_SQ_MUL: begin
				mul_a = 33'(c_k);
				mul_b = 33'(c_k);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		mul_q <= mul_p[63:0];
	end

	// Datapath arithmetic around the multiplier
	always_comb begin
		mv_rnd = mul_q + 64'sd2097152;
		mv_d   = 27'(mv_rnd >>> 22);
		if (func_q == FN_BACK || func_q == FN_LEFT) begin
			mv_sum = 33'(pos_k) - 33'(mv_d);
		end else begin
			mv_sum = 33'(pos_k) + 33'(mv_d);
		end
		if (mv_sum[32] != mv_sum[31]) begin
			mv_new = mv_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			mv_new = mv_sum[31:0];
		end

		pan_p = mul_q[32:0];
		pan_r = pan_p + 33'sd4096;
		pan_d = 20'(pan_r >>> 13);
		pit_s = 21'(pitch_q) + 21'(pan_d);
		pit_c = pit_s;
		if (pit_s > 21'sd32767) begin
			pit_c = 21'sd32767;
		end else if (pit_s < -21'sd32768) begin
			pit_c = -21'sd32768;
		end
		if (cons_q) begin
			if (pit_c > 21'(PITCH_LIM)) begin
				pit_c = 21'(PITCH_LIM);
			end else if (pit_c < -21'(PITCH_LIM)) begin
				pit_c = -21'(PITCH_LIM);
			end
		end

		zm_s = 21'(zoom_q) - 21'($signed({yo_q, 4'b0000}));
		zm_c = zm_s;
		if (zm_s < 21'(ZOOM_MIN)) begin
			zm_c = 21'(ZOOM_MIN);
		end else if (zm_s > 21'(ZOOM_MAX)) begin
			zm_c = 21'(ZOOM_MAX);
		end

		fr_r = mul_q + 64'sh0000_2000_0000_0000;
		fr_v = 18'(fr_r >>> 46);
		fy_r = 33'(cor_sin) + 33'sd32768;
		fy_v = 18'(fy_r >>> 16);

		dv_num = 46'({mag_k[30:0], 14'b0}) + 46'(len_q[31:1]);
		n_k    = c_k[31] ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
	end

	assign cor_start = (state_q == ST_COR_Y) || (state_q == ST_WAIT_Y && cor_done);
	assign cor_angle = (state_q == ST_WAIT_Y) ? pitch_q : yaw_q;
	assign sq_start  = (state_q == ST_SQ_GO);
	assign dv_start  = (state_q == ST_DIV_GO);

	ecam_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cor_start),
		.angle(cor_angle),
		.done(cor_done),
		.cos_val(cor_cos),
		.sin_val(cor_sin)
	);

	ecam_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.value(sum_q),
		.done(sq_done),
		.root(sq_root)
	);

	ecam_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(dv_start),
		.num(dv_num),
		.den(len_q),
		.done(dv_done),
		.quo(dv_quo)
	);

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	assign cfg_wr   = psel && penable && pwrite && pready;

	// Configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= 16'd640;
			sens_q      <= 16'd6554;
			wux_q       <= '0;
			wuy_q       <= 16'sd16384;
			wuz_q       <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_MAX_SPEED:   max_speed_q <= pwdata[15:0];
				REG_SENSITIVITY: sens_q      <= pwdata[15:0];
				REG_WORLD_UP_X:  wux_q       <= pwdata[15:0];
				REG_WORLD_UP_Y:  wuy_q       <= pwdata[15:0];
				REG_WORLD_UP_Z:  wuz_q       <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MAX_SPEED:   prdata = {16'b0, max_speed_q};
			REG_SENSITIVITY: prdata = {16'b0, sens_q};
			REG_WORLD_UP_X:  prdata = {16'b0, wux_q};
			REG_WORLD_UP_Y:  prdata = {16'b0, wuy_q};
			REG_WORLD_UP_Z:  prdata = {16'b0, wuz_q};
			default:         prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Hold the event fields
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_q <= func;
			dt_q   <= dt;
			xo_q   <= x_offset;
			yo_q   <= y_offset;
			cons_q <= constrain_pitch;
			pin0_q <= pos_x;
			pin1_q <= pos_y;
			pin2_q <= pos_z;
			yin_q  <= yaw_in;
			pin_q  <= pitch_in;
		end
	end

	// Work registers with no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_MV_VEL: vel_q <= mul_q[31:0];
			ST_PAN_X:  yaw_w_q <= 21'(yaw_q) + 21'(pan_d);
			ST_EVT:    yaw_w_q <= 21'(yin_q);
			ST_WRAP: begin
				if (yaw_w_q >= 21'(DEG180)) begin
					yaw_w_q <= yaw_w_q - 21'(DEG360);
				end else if (yaw_w_q < -21'(DEG180)) begin
					yaw_w_q <= yaw_w_q + 21'(DEG360);
				end
			end
			ST_WAIT_Y: begin
				if (cor_done) begin
					cos_yaw_q <= cor_cos;
					sin_yaw_q <= cor_sin;
				end
			end
			ST_WAIT_P: begin
				if (cor_done) begin
					cos_pit_q <= cor_cos;
				end
			end
			ST_CR_ACC: begin
				if (!t_q) begin
					ctmp_q <= mul_q[31:0];
				end else begin
					case (k_q)
						2'd0: c0_q <= ctmp_q - $signed(mul_q[31:0]);
						2'd1: c1_q <= ctmp_q - $signed(mul_q[31:0]);
						default: c2_q <= ctmp_q - $signed(mul_q[31:0]);
					endcase
				end
			end
			ST_CR_MUL: begin
				if (!t_q && k_q == 2'd0) begin
					sum_q <= '0;
				end
			end
			ST_SQ_ACC: sum_q <= sum_q + mul_q;
			ST_SQRT: begin
				if (sq_done) begin
					len_q <= sq_root;
				end
			end
			ST_DIV_WAIT: begin
				if (dv_done) begin
					if (k_q == 2'd0) begin
						n0_q <= n_k;
					end else if (k_q == 2'd1) begin
						n1_q <= n_k;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer and camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			t_q     <= 1'b0;
			phase_q <= 1'b0;
			kind_q  <= KIND_POS;
			pos0_q  <= '0;
			pos1_q  <= '0;
			pos2_q  <= '0;
			yaw_q   <= -16'(DEG90);
			pitch_q <= '0;
			zoom_q  <= 16'(ZOOM_MAX);
			front_q <= '{x: 16'sd0, y: 16'sd0, z: -16'sd16384};
			right_q <= '{x: 16'sd16384, y: 16'sd0, z: 16'sd0};
			up_q    <= '{x: 16'sd0, y: 16'sd16384, z: 16'sd0};
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_EVT;
					end
				end
				ST_EVT: begin
					case (func_q)
						FN_FWD, FN_BACK, FN_LEFT, FN_RIGHT: state_q <= ST_MV_VEL;
						FN_PAN: state_q <= ST_PAN_X;
						FN_ZOOM: begin
							zoom_q  <= zm_c[15:0];
							state_q <= ST_COR_Y;
						end
						FN_POSE: begin
							pos0_q  <= pin0_q;
							pos1_q  <= pin1_q;
							pos2_q  <= pin2_q;
							pitch_q <= pin_q;
							state_q <= ST_WRAP;
						end
						default: state_q <= ST_COR_Y;
					endcase
				end
				ST_MV_VEL: begin
					k_q     <= 2'd0;
					state_q <= ST_MV_MUL;
				end
				ST_MV_MUL: state_q <= ST_MV_ACC;
				ST_MV_ACC: begin
					case (k_q)
						2'd0: pos0_q <= mv_new;
						2'd1: pos1_q <= mv_new;
						default: pos2_q <= mv_new;
					endcase
					if (k_q == 2'd2) begin
						state_q <= ST_COR_Y;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_MV_MUL;
					end
				end
				ST_PAN_X: state_q <= ST_PAN_Y;
				ST_PAN_Y: begin
					pitch_q <= pit_c[15:0];
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					if (yaw_w_q < 21'(DEG180) && yaw_w_q >= -21'(DEG180)) begin
						yaw_q   <= yaw_w_q[15:0];
						state_q <= ST_COR_Y;
					end
				end
				ST_COR_Y: state_q <= ST_WAIT_Y;
				ST_WAIT_Y: begin
					if (cor_done) begin
						state_q <= ST_WAIT_P;
					end
				end
				ST_WAIT_P: begin
					if (cor_done) begin
						front_q.y <= sat16(fy_v);
						state_q   <= ST_FR_X;
					end
				end
				ST_FR_X: begin
					front_q.x <= sat16(fr_v);
					state_q   <= ST_FR_Z;
				end
				ST_FR_Z: begin
					front_q.z <= sat16(fr_v);
					phase_q   <= 1'b0;
					k_q       <= 2'd0;
					t_q       <= 1'b0;
					state_q   <= ST_CR_MUL;
				end
				ST_CR_MUL: state_q <= ST_CR_ACC;
				ST_CR_ACC: begin
					if (!t_q) begin
						t_q     <= 1'b1;
						state_q <= ST_CR_MUL;
					end else begin
						t_q <= 1'b0;
						if (k_q == 2'd2) begin
							k_q     <= 2'd0;
							state_q <= ST_SQ_MUL;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_CR_MUL;
						end
					end
				end
				ST_SQ_MUL: state_q <= ST_SQ_ACC;
				ST_SQ_ACC: begin
					if (k_q == 2'd2) begin
						k_q     <= 2'd0;
						state_q <= ST_SQ_GO;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_SQ_MUL;
					end
				end
				ST_SQ_GO: state_q <= ST_SQRT;
				ST_SQRT: begin
					if (sq_done) begin
						// A zero cross product keeps the previous vectors
						state_q <= (sq_root == '0) ? ST_OUT : ST_DIV_GO;
					end
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (dv_done) begin
						if (k_q == 2'd2) begin
							k_q <= 2'd0;
							if (!phase_q) begin
								right_q <= '{x: n0_q, y: n1_q, z: n_k};
								phase_q <= 1'b1;
								t_q     <= 1'b0;
								state_q <= ST_CR_MUL;
							end else begin
								up_q    <= '{x: n0_q, y: n1_q, z: n_k};
								state_q <= ST_OUT;
							end
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_OUT: begin
					if (out_take) begin
						if (kind_q == KIND_YPZ) begin
							kind_q  <= KIND_POS;
							state_q <= ST_IDLE;
						end else begin
							kind_q <= kind_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result beat fields
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign kind      = kind_q;
	assign last      = (kind_q == KIND_YPZ);

	always_comb begin
		case (kind_q)
			KIND_POS: begin
				comp_a = pos0_q;
				comp_b = pos1_q;
				comp_c = pos2_q;
			end
			KIND_FRONT: begin
				comp_a = 32'(front_q.x);
				comp_b = 32'(front_q.y);
				comp_c = 32'(front_q.z);
			end
			KIND_RIGHT: begin
				comp_a = 32'(right_q.x);
				comp_b = 32'(right_q.y);
				comp_c = 32'(right_q.z);
			end
			KIND_UP: begin
				comp_a = 32'(up_q.x);
				comp_b = 32'(up_q.y);
				comp_c = 32'(up_q.z);
			end
			default: begin
				comp_a = 32'(yaw_q);
				comp_b = 32'(pitch_q);
				comp_c = 32'(zoom_q);
			end
		endcase
	end

	`ECAM_ASSERT_NOW(a_no_take_while_out, out_valid, in_stall)
	`ECAM_ASSERT_NEXT(a_last_ends_run, out_valid && !out_stall && last, !out_valid)
	`ECAM_ASSERT_NOW(a_zoom_range, 1'b1, (zoom_q >= 16'(ZOOM_MIN)) && (zoom_q <= 16'(ZOOM_MAX)))
	`ECAM_ASSERT_NOW(a_yaw_range, state_q == ST_IDLE, (yaw_q >= -16'(DEG180)) && (yaw_q < 16'(DEG180)))

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the fly camera pose update unit.
`timescale 1ns / 100ps
module tb_top;
	import ecam_pkg::*;

	localparam int LATENCY    = 300;
	localparam int WDOG_LIMIT = 5000;
	localparam int LONG_HOLD  = 900;

	typedef struct {
		logic [2:0]         func;
		logic [15:0]        dt;
		logic signed [15:0] x_offset;
		logic signed [15:0] y_offset;
		logic               constrain_pitch;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] yaw_in;
		logic signed [15:0] pitch_in;
	} cam_event_t;

	typedef struct {
		logic [2:0]         kind;
		logic signed [31:0] comp_a;
		logic signed [31:0] comp_b;
		logic signed [31:0] comp_c;
		logic               last;
	} pose_beat_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         func = FN_REPORT;
	logic [15:0]        dt = '0;
	logic signed [15:0] x_offset = '0;
	logic signed [15:0] y_offset = '0;
	logic               constrain_pitch = 1'b0;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [31:0] pos_z = '0;
	logic signed [15:0] yaw_in = '0;
	logic signed [15:0] pitch_in = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         kind;
	logic signed [31:0] comp_a;
	logic signed [31:0] comp_b;
	logic signed [31:0] comp_c;
	logic               last;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	// Pose and register copy kept by the predictor
	logic [15:0]        speed_cfg, sens_cfg;
	logic signed [15:0] wup_cfg [3];
	longint             pos_st [3];
	int                 yaw_st, pitch_st, zoom_st;
	logic signed [15:0] front_st [3], right_st [3], up_st [3];

	pose_beat_t pose_beats_q [$];
	int         err_cnt = 0;
	int         events_sent = 0;
	int         beats_seen = 0;
	int         cfg_writes = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         hold_req = 0;
	int         quiet_cycles = 0;

	longint atan_deg [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
		29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

	euler_fly_camera_update_unit DUT (.*);

	always #5 clk = ~clk;

	function automatic longint rnd_shr(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int wrap360(longint a);
		longint m;
		m = a % DEG360;
		if (m < 0) m += DEG360;
		if (m >= DEG180) m -= DEG360;
		return int'(m);
	endfunction

	// Cosine and sine of a Q9.7 angle, Q1.30, by CORDIC rotation
	function automatic void cordic_sincos(input int ang, output longint c, output longint s);
		int     a;
		bit     flip;
		longint x, y, z, nx;
		a = wrap360(ang);
		flip = 1'b0;
		if (a > DEG90) begin
			a -= DEG180;
			flip = 1'b1;
		end else if (a < -DEG90) begin
			a += DEG180;
			flip = 1'b1;
		end
		x = CORDIC_GAIN;
		y = 0;
		z = longint'(a) * 512;
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_deg[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_deg[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, bm;
		r = 0;
		bm = 64'd1 << 62;
		while (bm > v) bm >>= 2;
		while (bm != 0) begin
			if (v >= r + bm) begin
				v -= r + bm;
				r = (r >> 1) + bm;
			end else begin
				r >>= 1;
			end
			bm >>= 2;
		end
		return r;
	endfunction

	// Normalised cross product; returns 0 when the product has zero length
	function automatic bit unit_cross(input longint a [3], input longint b [3],
			output logic signed [15:0] o [3]);
		longint          c [3];
		longint unsigned mag [3];
		longint unsigned sum, len, q;
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = (c[k] < 0) ? longint'(-c[k]) : c[k];
			sum += mag[k] * mag[k];
		end
		len = int_sqrt(sum);
		if (len == 0) return 1'b0;
		for (int k = 0; k < 3; k++) begin
			q = (mag[k] * 16384 + len / 2) / len;
			o[k] = (c[k] < 0) ? 16'(-longint'(q)) : 16'(q);
		end
		return 1'b1;
	endfunction

	function automatic void refresh_axes();
		longint             cy, sy, cp, sp;
		longint             fa [3], wa [3], ra [3];
		logic signed [15:0] r [3], u [3];
		cordic_sincos(yaw_st, cy, sy);
		cordic_sincos(pitch_st, cp, sp);
		front_st[0] = 16'(clip(rnd_shr(cy * cp, 46), -32768, 32767));
		front_st[1] = 16'(clip(rnd_shr(sp, 16), -32768, 32767));
		front_st[2] = 16'(clip(rnd_shr(sy * cp, 46), -32768, 32767));
		for (int k = 0; k < 3; k++) begin
			fa[k] = front_st[k];
			wa[k] = wup_cfg[k];
		end
		if (!unit_cross(fa, wa, r)) return;
		for (int k = 0; k < 3; k++) begin
			right_st[k] = r[k];
			ra[k] = r[k];
		end
		if (unit_cross(ra, fa, u))
			for (int k = 0; k < 3; k++) up_st[k] = u[k];
	endfunction

	function automatic void queue_beat(logic [2:0] k, longint a, longint b, longint c);
		pose_beat_t pb;
		pb.kind = k;
		pb.comp_a = 32'(a);
		pb.comp_b = 32'(b);
		pb.comp_c = 32'(c);
		pb.last = (k == KIND_YPZ);
		pose_beats_q.push_back(pb);
	endfunction

	// Apply one accepted event to the pose and queue the five result beats
	function automatic void advance_pose(cam_event_t e);
		longint vel, d, dx, dy, p;
		bit     neg;
		vel = longint'(speed_cfg) * longint'(e.dt);
		case (e.func)
			FN_FWD, FN_BACK, FN_LEFT, FN_RIGHT: begin
				neg = (e.func == FN_BACK) || (e.func == FN_LEFT);
				for (int k = 0; k < 3; k++) begin
					d = rnd_shr(longint'((e.func == FN_FWD || e.func == FN_BACK) ?
						front_st[k] : right_st[k]) * vel, 22);
					pos_st[k] = clip(pos_st[k] + (neg ? -d : d), -64'sd2147483648, 64'sd2147483647);
				end
			end
			FN_PAN: begin
				dx = rnd_shr(longint'(e.x_offset) * longint'(sens_cfg), 13);
				dy = rnd_shr(longint'(e.y_offset) * longint'(sens_cfg), 13);
				yaw_st = wrap360(longint'(yaw_st) + dx);
				p = clip(longint'(pitch_st) + dy, -32768, 32767);
				if (e.constrain_pitch) p = clip(p, -PITCH_LIM, PITCH_LIM);
				pitch_st = int'(p);
			end
			FN_ZOOM: zoom_st = int'(clip(longint'(zoom_st) - longint'(e.y_offset) * 16,
				ZOOM_MIN, ZOOM_MAX));
			FN_POSE: begin
				pos_st[0] = e.pos_x;
				pos_st[1] = e.pos_y;
				pos_st[2] = e.pos_z;
				yaw_st = wrap360(longint'(e.yaw_in));
				pitch_st = e.pitch_in;
			end
			default: ;
		endcase
		refresh_axes();
		queue_beat(KIND_POS, pos_st[0], pos_st[1], pos_st[2]);
		queue_beat(KIND_FRONT, front_st[0], front_st[1], front_st[2]);
		queue_beat(KIND_RIGHT, right_st[0], right_st[1], right_st[2]);
		queue_beat(KIND_UP, up_st[0], up_st[1], up_st[2]);
		queue_beat(KIND_YPZ, yaw_st, pitch_st, zoom_st);
	endfunction

	function automatic void reset_pose();
		speed_cfg = 640;
		sens_cfg = 6554;
		wup_cfg = '{16'sd0, 16'sd16384, 16'sd0};
		pos_st = '{0, 0, 0};
		yaw_st = -DEG90;
		pitch_st = 0;
		zoom_st = ZOOM_MAX;
		front_st = '{16'sd0, 16'sd0, -16'sd16384};
		right_st = '{16'sd16384, 16'sd0, 16'sd0};
		up_st = '{16'sd0, 16'sd16384, 16'sd0};
	endfunction

	function automatic cam_event_t rand_event();
		cam_event_t e;
		e.func = 3'($urandom_range(0, 7));
		e.dt = 16'($urandom);
		e.x_offset = 16'($urandom);
		e.y_offset = 16'($urandom);
		e.constrain_pitch = 1'($urandom);
		e.pos_x = $urandom;
		e.pos_y = $urandom;
		e.pos_z = $urandom;
		e.yaw_in = 16'($urandom);
		e.pitch_in = 16'($urandom);
		return e;
	endfunction

	// Offer one event; predict its beats at the accepting edge
	task automatic send_event(cam_event_t e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func = e.func;
		dt = e.dt;
		x_offset = e.x_offset;
		y_offset = e.y_offset;
		constrain_pitch = e.constrain_pitch;
		pos_x = e.pos_x;
		pos_y = e.pos_y;
		pos_z = e.pos_z;
		yaw_in = e.yaw_in;
		pitch_in = e.pitch_in;
		do @(posedge clk); while (in_stall);
		advance_pose(e);
		events_sent++;
		@(negedge clk);
	endtask

	task automatic drain_beats();
		in_valid = 1'b0;
		while (pose_beats_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		drain_beats();
		repeat (LATENCY) @(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = {16'd0, val};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_MAX_SPEED:   speed_cfg = val;
			REG_SENSITIVITY: sens_cfg = val;
			REG_WORLD_UP_X:  wup_cfg[0] = val;
			REG_WORLD_UP_Y:  wup_cfg[1] = val;
			REG_WORLD_UP_Z:  wup_cfg[2] = val;
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic send_fn(logic [2:0] f);
		cam_event_t e;
		e = rand_event();
		e.func = f;
		send_event(e);
	endtask

	task automatic send_pose(logic signed [31:0] px, logic signed [15:0] yw,
			logic signed [15:0] pt);
		cam_event_t e;
		e = rand_event();
		e.func = FN_POSE;
		e.pos_x = px;
		e.pos_y = -px;
		e.pos_z = px;
		e.yaw_in = yw;
		e.pitch_in = pt;
		send_event(e);
	endtask

	task automatic send_pan(logic signed [15:0] xo, logic signed [15:0] yo, logic cons);
		cam_event_t e;
		e = rand_event();
		e.func = FN_PAN;
		e.x_offset = xo;
		e.y_offset = yo;
		e.constrain_pitch = cons;
		send_event(e);
	endtask

	task automatic send_move(logic [2:0] f, logic [15:0] d);
		cam_event_t e;
		e = rand_event();
		e.func = f;
		e.dt = d;
		send_event(e);
	endtask

	// Field extremes, every event code, clamps, wraps and the degenerate cross product
	task automatic test_directed();
		cam_event_t e;
		send_fn(FN_REPORT);
		send_move(FN_FWD, 16'hFFFF);
		send_move(FN_BACK, 16'h8000);
		send_move(FN_LEFT, 16'hFFFF);
		send_move(FN_RIGHT, 16'h0000);
		send_pan(16'sh7FFF, 16'sh7FFF, 1'b1);
		send_pan(-16'sh8000, -16'sh8000, 1'b1);
		send_pan(16'sh7FFF, 16'sh7FFF, 1'b0);
		send_pan(16'sh7FFF, 16'sh7FFF, 1'b0);
		send_pan(-16'sh8000, -16'sh8000, 1'b0);
		send_pan(-16'sh8000, -16'sh8000, 1'b0);
		e = rand_event();
		e.func = FN_ZOOM;
		e.y_offset = 16'sh7FFF;
		send_event(e);
		e.y_offset = -16'sh8000;
		send_event(e);
		e.y_offset = 16'sd20;
		send_event(e);
		send_pose(32'sh7FFFFFFF, -16'sh8000, 16'sh7FFF);
		send_move(FN_FWD, 16'hFFFF);
		send_move(FN_RIGHT, 16'hFFFF);
		send_pose(-32'sh80000000, 16'sh7FFF, -16'sh8000);
		send_move(FN_BACK, 16'hFFFF);
		send_pose(32'sd0, 16'sd23039, -16'sd23040);
		// Looking straight up: front parallel to world up, keep right and up
		send_pose(32'sd65536, 16'sd0, 16'sd11520);
		send_pose(32'sd65536, 16'sd5000, -16'sd11520);
		send_pan(16'sd0, 16'sd0, 1'b1);
	endtask

	task automatic test_random(int n);
		repeat (n) send_event(rand_event());
	endtask

	// Register settings including extremes and a zero world up
	task automatic test_config();
		write_reg(REG_MAX_SPEED, 16'hFFFF);
		write_reg(REG_SENSITIVITY, 16'hFFFF);
		test_random(15);
		write_reg(REG_MAX_SPEED, 16'h0000);
		write_reg(REG_SENSITIVITY, 16'h0000);
		write_reg(REG_WORLD_UP_X, 16'h7FFF);
		write_reg(REG_WORLD_UP_Y, 16'h8000);
		write_reg(REG_WORLD_UP_Z, 16'h7FFF);
		test_random(15);
		write_reg(REG_WORLD_UP_X, 16'h0000);
		write_reg(REG_WORLD_UP_Y, 16'h0000);
		write_reg(REG_WORLD_UP_Z, 16'h0000);
		test_random(10);
		write_reg(REG_MAX_SPEED, 16'($urandom));
		write_reg(REG_SENSITIVITY, 16'($urandom));
		write_reg(REG_WORLD_UP_X, 16'($urandom));
		write_reg(REG_WORLD_UP_Y, 16'($urandom));
		write_reg(REG_WORLD_UP_Z, 16'($urandom));
		test_random(15);
		write_reg(REG_MAX_SPEED, 16'd640);
		write_reg(REG_SENSITIVITY, 16'd6554);
		write_reg(REG_WORLD_UP_X, 16'd0);
		write_reg(REG_WORLD_UP_Y, 16'd16384);
		write_reg(REG_WORLD_UP_Z, 16'd0);
	endtask

	// Receiver holds off while the sender keeps offering events, then the sender waits for a full drain
	task automatic test_backpressure();
		hold_req = LONG_HOLD;
		test_random(6);
		drain_beats();
		test_random(6);
	endtask

	// Receiver: random stalls, or a long counted hold when asked
	always @(negedge clk) begin
		int hold_left;
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
			out_stall = 1'b1;
			repeat (hold_left) @(negedge clk);
		end
		out_stall = ($urandom_range(99) < recv_idle_pct);
	end

	// Compare each accepted beat with the oldest expectation
	always @(posedge clk) begin
		pose_beat_t pb;
		if (arst_n && out_valid && !out_stall) begin
			beats_seen++;
			if (pose_beats_q.size() == 0) begin
				$error("unexpected beat: kind %0d", kind);
				err_cnt++;
			end else begin
				pb = pose_beats_q.pop_front();
				if (kind !== pb.kind) begin
					$error("kind: expected %0d, got %0d", pb.kind, kind);
					err_cnt++;
				end
				if (comp_a !== pb.comp_a) begin
					$error("comp_a: expected %0d, got %0d", pb.comp_a, comp_a);
					err_cnt++;
				end
				if (comp_b !== pb.comp_b) begin
					$error("comp_b: expected %0d, got %0d", pb.comp_b, comp_b);
					err_cnt++;
				end
				if (comp_c !== pb.comp_c) begin
					$error("comp_c: expected %0d, got %0d", pb.comp_c, comp_c);
					err_cnt++;
				end
				if (last !== pb.last) begin
					$error("last: expected %0d, got %0d", pb.last, last);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles with no event, beat or register write accepted
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		reset_pose();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_idle_pct = 20;
		recv_idle_pct = 70;
		test_directed();
		test_config();
		test_random(60);
		send_idle_pct = 70;
		recv_idle_pct = 20;
		test_random(60);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random(60);
		drain_beats();
		repeat (LATENCY) @(negedge clk);
		if (pose_beats_q.size() != 0) begin
			$error("%0d beats never arrived", pose_beats_q.size());
			err_cnt++;
		end
		$display("Covered %0d events (all codes, field extremes, long hold-off) and %0d beats,",
			events_sent, beats_seen);
		$display("with %0d register writes across speed, sensitivity and world up settings.",
			cfg_writes);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
